### hdl/upts_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// upts_pkg
// Shared constants, types and the name normalization function of the
// unique prefix table search block.
// ============================================================================
package upts_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_CHARS   = 8;

    localparam int NAME_W  = 64;
    localparam int ENTRY_W = 8;
    localparam int CNT_W   = 9;
    localparam int STAT_W  = 2;
    localparam int MIDX_W  = 8;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int N_W   = IDX_W + 1;
    localparam int POS_W = IDX_W + 2;

    localparam int S_TDATA_W = ENTRY_W + NAME_W;
    localparam int M_TDATA_W = ((STAT_W + MIDX_W + 7) / 8) * 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] ST_MATCH     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_AMBIGUOUS = 2'd2;

    typedef struct packed {
        logic [NAME_W-1:0] key;
        logic [NAME_W-1:0] mask;
    } t_norm;

    // Keeps the bytes up to the first zero byte within the top KEY_CHARS bytes.
    function automatic t_norm norm_name(logic [NAME_W-1:0] v);
        t_norm      r;
        logic       alive;
        logic [7:0] b;
        r.key  = '0;
        r.mask = '0;
        alive  = 1'b1;
        for (int i = 0; i < KEY_CHARS; i++) begin
            b = v[NAME_W-1-8*i -: 8];
            if (b == 8'h00) begin
                alive = 1'b0;
            end
            if (alive) begin
                r.key[NAME_W-1-8*i -: 8]  = b;
                r.mask[NAME_W-1-8*i -: 8] = 8'hFF;
            end
        end
        return r;
    endfunction

endpackage

### hdl/unique_prefix_table_search.sv
`timescale 1ns / 1ps
// ============================================================================
// unique_prefix_table_search
// Sorted name table with binary search and unique prefix resolution.
// ============================================================================
// A write transaction (tuser = 0) stores one normalized name in a 64-bit wide
// synchronous table. A query transaction (tuser = 1) binary-searches the first
// entry_count entries, with entry_count limited to the table depth, and returns
// one result: exact or unique prefix match with its index, not found, or prefix
// not unique. A query occupies the engine until its result is loaded into the
// output register; the single read port of the table issues one probe per
// cycle while it searches. An empty key or an empty table skips the search and
// answers not found. A finished result waits in an output register, so the
// next item is taken while it is still pending. The table has no reset and no
// clearing pass; only entries that were written may be searched.
// ============================================================================
module unique_prefix_table_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration: entry_count
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [upts_pkg::CNT_W-1:0]      i_cfg_data,
    // Input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [upts_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // entry_index, name_text
    input  logic [0:0]                      s_axis_tuser,  // operation
    // Results
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [upts_pkg::M_TDATA_W-1:0]  m_axis_tdata   // status, match_index, zero pad
);
    import upts_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_NEXT   = 3'd2;
    localparam logic [2:0] S_AFTER  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [NAME_W-1:0] mem [TABLE_DEPTH];

    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_entry_count;
    logic                    r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]    r_out_data, n_out_data;
    logic [NAME_W-1:0]       r_key, n_key;
    logic [NAME_W-1:0]       r_kmask, n_kmask;
    logic [N_W-1:0]          r_n, n_n;
    logic signed [POS_W-1:0] r_lower, n_lower;
    logic signed [POS_W-1:0] r_upper, n_upper;
    logic [IDX_W-1:0]        r_pos, n_pos;
    logic [STAT_W-1:0]       r_status, n_status;
    logic [IDX_W-1:0]        r_index, n_index;
    logic [NAME_W-1:0]       r_rd_data;

    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;

    logic                    in_accept;
    logic [ENTRY_W-1:0]      in_entry;
    logic [NAME_W-1:0]       in_name;
    t_norm                   in_norm;
    logic [N_W-1:0]          in_n;
    logic [N_W-1:0]          in_n_m1;

    logic                    e_lt, e_gt, e_eq, e_sw;
    logic signed [POS_W-1:0] s_pos, nl, nu, sum;
    logic [N_W-1:0]          pos_inc;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_entry  = s_axis_tdata[ENTRY_W-1:0];
    assign in_name   = s_axis_tdata[S_TDATA_W-1:ENTRY_W];
    assign in_norm   = norm_name(in_name);
    assign in_n      = (int'(r_entry_count) > TABLE_DEPTH) ? N_W'(TABLE_DEPTH)
                                                            : N_W'(r_entry_count);
    assign in_n_m1   = in_n - N_W'(1);

    assign wr_en   = in_accept && (s_axis_tuser[0] == OP_WRITE)
                     && (int'(in_entry) < TABLE_DEPTH);
    assign wr_addr = IDX_W'(in_entry);

    // Compare of the entry read in the previous cycle against the key.
    assign e_lt    = r_rd_data < r_key;
    assign e_gt    = r_rd_data > r_key;
    assign e_eq    = r_rd_data == r_key;
    assign e_sw    = (r_rd_data & r_kmask) == r_key;
    assign s_pos   = signed'(POS_W'(r_pos));
    assign nl      = e_gt ? r_lower : s_pos + POS_W'(1);
    assign nu      = e_lt ? r_upper : s_pos - POS_W'(1);
    assign sum     = nl + nu;
    assign pos_inc = N_W'(r_pos) + N_W'(1);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_key       = r_key;
        n_kmask     = r_kmask;
        n_n         = r_n;
        n_lower     = r_lower;
        n_upper     = r_upper;
        n_pos       = r_pos;
        n_status    = r_status;
        n_index     = r_index;
        rd_addr     = r_pos;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (s_axis_tuser[0] == OP_QUERY)) begin
                    n_key    = in_norm.key;
                    n_kmask  = in_norm.mask;
                    n_n      = in_n;
                    n_lower  = '0;
                    n_upper  = signed'(POS_W'(in_n)) - POS_W'(1);
                    n_pos    = in_n_m1[IDX_W:1];
                    rd_addr  = in_n_m1[IDX_W:1];
                    n_status = ST_NOT_FOUND;
                    n_index  = '0;
                    if (in_norm.key == '0 || in_n == '0) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                n_lower = nl;
                n_upper = nu;
                if (nl <= nu) begin
                    n_pos   = sum[IDX_W:1];
                    rd_addr = sum[IDX_W:1];
                end else if (e_eq) begin
                    n_status = ST_MATCH;
                    n_index  = r_pos;
                    n_state  = S_RESULT;
                end else if (e_sw) begin
                    // Prefix hit at the last probe: see whether the next one also fits.
                    if (pos_inc < r_n) begin
                        rd_addr = pos_inc[IDX_W-1:0];
                        n_state = S_AFTER;
                    end else begin
                        n_status = ST_MATCH;
                        n_index  = r_pos;
                        n_state  = S_RESULT;
                    end
                end else if (pos_inc >= r_n) begin
                    n_state = S_RESULT;
                end else begin
                    n_pos   = pos_inc[IDX_W-1:0];
                    rd_addr = pos_inc[IDX_W-1:0];
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!e_sw) begin
                    n_state = S_RESULT;
                end else if (pos_inc < r_n) begin
                    rd_addr = pos_inc[IDX_W-1:0];
                    n_state = S_AFTER;
                end else begin
                    n_status = ST_MATCH;
                    n_index  = r_pos;
                    n_state  = S_RESULT;
                end
            end
            S_AFTER: begin
                if (e_sw) begin
                    n_status = ST_AMBIGUOUS;
                end else begin
                    n_status = ST_MATCH;
                    n_index  = r_pos;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = M_TDATA_W'({MIDX_W'(r_index), r_status});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_count <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_entry_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_key      <= n_key;
        r_kmask    <= n_kmask;
        r_n        <= n_n;
        r_lower    <= n_lower;
        r_upper    <= n_upper;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_index    <= n_index;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_norm.key;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule

### hdl/upts_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// upts_checker
// Port-level checks for the unique prefix table search block.
// ============================================================================
module upts_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [0:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [upts_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import upts_pkg::*;

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A result that is not taken stays unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Only a match carries an index.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[STAT_W-1:0] != ST_MATCH)
        |-> m_axis_tdata[STAT_W+MIDX_W-1:STAT_W] == '0)
        else $error("index given without a match");

    // A query keeps the engine busy for at least the following cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_QUERY)
        |=> !s_axis_tready)
        else $error("engine free right after a query");

    // A table write completes in the cycle it is taken.
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_WRITE)
        |=> s_axis_tready)
        else $error("engine stalled after a write");

endmodule

bind unique_prefix_table_search upts_checker u_upts_checker (.*);
